@@ hw/rtl/icru_pkg.sv @@
// ----------------------------------------------------------------------------
// ICMP reply classifier package
// Shared constants, codes and the packet summary passed from parser to
// classifier.
// ----------------------------------------------------------------------------
package icru_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 4096;

  // Clamped packet length: every length check compares against at most 136
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned LEN_SAT = 255;
  localparam int unsigned HLEN_W  = 6;

  localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
  localparam int unsigned IP_MIN_HDR = 20;
  localparam int unsigned ICMP_HDR   = 8;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_IDENT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SEQUENCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ADDRESS    = 2'd2;

  typedef enum logic [1:0] {
    VERDICT_TOO_SHORT = 2'd0,
    VERDICT_IGNORED   = 2'd1,
    VERDICT_HOP       = 2'd2,
    VERDICT_DEST      = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [HLEN_W-1:0] outer_hlen;
    logic [7:0]        reply_type;
    logic [HLEN_W-1:0] inner_hlen;
    logic [31:0]       source;
    logic [31:0]       outer_ident_seq;
    logic [31:0]       inner_ident_seq;
  } pkt_summary_t;

endpackage

@@ hw/rtl/icru_if.sv @@
// ----------------------------------------------------------------------------
// ICMP reply classifier channels
// Byte input channel and verdict result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface icru_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pkt_byte;
  logic       last_byte;

  modport source (output valid, output pkt_byte, output last_byte, input ready);
  modport sink   (input valid, input pkt_byte, input last_byte, output ready);
endinterface

interface icru_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [31:0] source_address;

  modport source (output valid, output verdict, output source_address, input ready);
  modport sink   (input valid, input verdict, input source_address, output ready);
endinterface

@@ hw/rtl/icru_parser.sv @@
// ----------------------------------------------------------------------------
// ICMP reply parser
// Walks the packet one byte a beat, picks out header fields and pushes one
// summary to the queue on the last byte.
// ----------------------------------------------------------------------------
module icru_parser #(
  parameter int unsigned MAX_PACKET_BYTES = icru_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  icru_in_if.sink               in_ch,
  input  logic                  q_full,
  output logic                  q_push,
  output icru_pkg::pkt_summary_t q_data
);
  import icru_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  logic [CNT_W-1:0]  count_r, count_nxt, count_upd;
  logic [HLEN_W-1:0] ohl_r, ohl_nxt, ohl_upd;
  logic [HLEN_W-1:0] ihl_r, ihl_nxt, ihl_upd;
  logic [7:0]        type_r, type_nxt, type_upd;
  logic [31:0]       src_r, src_nxt, src_upd;
  logic [31:0]       oid_r, oid_nxt, oid_upd;
  logic [31:0]       iid_r, iid_nxt, iid_upd;

  logic             accept, take;
  logic [CMP_W-1:0] idx, ohl_ext, inner_start, count_ext;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign take        = count_r < CNT_W'(MAX_PACKET_BYTES);
  assign idx         = CMP_W'(count_r);

  always_comb begin
    ohl_upd  = ohl_r;
    ihl_upd  = ihl_r;
    type_upd = type_r;
    src_upd  = src_r;
    oid_upd  = oid_r;
    iid_upd  = iid_r;
    if (take) begin
      if (count_r == '0) begin
        ohl_upd = {in_ch.pkt_byte[3:0], 2'b00};
      end
    end
    ohl_ext = CMP_W'(ohl_upd);
    if (take) begin
      if (idx >= CMP_W'(12) && idx < CMP_W'(16)) begin
        src_upd = {src_r[23:0], in_ch.pkt_byte};
      end
      if (idx == ohl_ext) begin
        type_upd = in_ch.pkt_byte;
      end
      if (idx >= ohl_ext + CMP_W'(4) && idx < ohl_ext + CMP_W'(ICMP_HDR)) begin
        oid_upd = {oid_r[23:0], in_ch.pkt_byte};
      end
      if (idx == ohl_ext + CMP_W'(ICMP_HDR)) begin
        ihl_upd = {in_ch.pkt_byte[3:0], 2'b00};
      end
    end
    inner_start = ohl_ext + CMP_W'(ICMP_HDR) + CMP_W'(ihl_upd);
    if (take && idx >= inner_start + CMP_W'(4) && idx < inner_start + CMP_W'(8)) begin
      iid_upd = {iid_r[23:0], in_ch.pkt_byte};
    end
    count_upd = take ? count_r + CNT_W'(1) : count_r;
    count_ext = CMP_W'(count_upd);

    q_data.len             = (count_ext > CMP_W'(LEN_SAT)) ? LEN_W'(LEN_SAT)
                                                           : LEN_W'(count_ext);
    q_data.outer_hlen      = ohl_upd;
    q_data.reply_type      = type_upd;
    q_data.inner_hlen      = ihl_upd;
    q_data.source          = src_upd;
    q_data.outer_ident_seq = oid_upd;
    q_data.inner_ident_seq = iid_upd;
    q_push                 = accept && in_ch.last_byte;

    count_nxt = count_r;
    ohl_nxt   = ohl_r;
    ihl_nxt   = ihl_r;
    type_nxt  = type_r;
    src_nxt   = src_r;
    oid_nxt   = oid_r;
    iid_nxt   = iid_r;
    if (accept) begin
      if (in_ch.last_byte) begin
        // clear for the next packet
        count_nxt = '0;
        ohl_nxt   = '0;
        ihl_nxt   = '0;
        type_nxt  = '0;
        src_nxt   = '0;
        oid_nxt   = '0;
        iid_nxt   = '0;
      end else begin
        count_nxt = count_upd;
        ohl_nxt   = ohl_upd;
        ihl_nxt   = ihl_upd;
        type_nxt  = type_upd;
        src_nxt   = src_upd;
        oid_nxt   = oid_upd;
        iid_nxt   = iid_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ohl_r   <= '0;
      ihl_r   <= '0;
      type_r  <= '0;
      src_r   <= '0;
      oid_r   <= '0;
      iid_r   <= '0;
    end else begin
      count_r <= count_nxt;
      ohl_r   <= ohl_nxt;
      ihl_r   <= ihl_nxt;
      type_r  <= type_nxt;
      src_r   <= src_nxt;
      oid_r   <= oid_nxt;
      iid_r   <= iid_nxt;
    end
  end

endmodule

@@ hw/rtl/icru_queue.sv @@
// ----------------------------------------------------------------------------
// ICMP reply summary queue
// Short register queue decoupling the parser from the classifier.
// ----------------------------------------------------------------------------
module icru_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  icru_pkg::pkt_summary_t push_data,
  output logic                  full,
  input  logic                  pop,
  output icru_pkg::pkt_summary_t pop_data,
  output logic                  empty
);
  import icru_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  pkt_summary_t     slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign full     = fill_r == CNT_W'(QUEUE_DEPTH);
  assign empty    = fill_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/icru_classifier.sv @@
// ----------------------------------------------------------------------------
// ICMP reply classifier back end
// Holds the match registers, turns a packet summary into a verdict and
// drives the registered result channel.
// ----------------------------------------------------------------------------
module icru_classifier (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [icru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [icru_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            q_empty,
  input  icru_pkg::pkt_summary_t          q_data,
  output logic                            q_pop,
  icru_out_if.source                      out_ch
);
  import icru_pkg::*;

  logic [15:0] ident_r, seq_r;
  logic [31:0] target_r;
  logic        out_valid_r, out_valid_nxt;
  verdict_t    verdict_r, verdict_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] want;
  logic [8:0]  n, ohl, ihl;

  assign want = {ident_r, seq_r};
  assign n    = 9'(q_data.len);
  assign ohl  = 9'(q_data.outer_hlen);
  assign ihl  = 9'(q_data.inner_hlen);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_r  <= '0;
      seq_r    <= '0;
      target_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXPECTED_IDENT:    ident_r  <= cfg_data[15:0];
        CFG_EXPECTED_SEQUENCE: seq_r    <= cfg_data[15:0];
        CFG_TARGET_ADDRESS:    target_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    q_pop         = !q_empty && (!out_valid_r || out_ch.ready);
    out_valid_nxt = out_valid_r && !out_ch.ready;
    verdict_nxt   = verdict_r;
    src_nxt       = src_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      src_nxt       = q_data.source;
      if (n < 9'(IP_MIN_HDR) || n < ohl + 9'(ICMP_HDR)) begin
        verdict_nxt = VERDICT_TOO_SHORT;
      end else if (q_data.reply_type == TYPE_TIME_EXCEEDED) begin
        if (n < ohl + 9'(ICMP_HDR + IP_MIN_HDR) ||
            n < ohl + ihl + 9'(2 * ICMP_HDR)) begin
          verdict_nxt = VERDICT_TOO_SHORT;
        end else begin
          verdict_nxt = (q_data.inner_ident_seq == want) ? VERDICT_HOP : VERDICT_IGNORED;
        end
      end else if (q_data.reply_type == TYPE_ECHO_REPLY) begin
        verdict_nxt = (q_data.outer_ident_seq == want && q_data.source == target_r)
                      ? VERDICT_DEST : VERDICT_IGNORED;
      end else begin
        verdict_nxt = VERDICT_IGNORED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
    src_r     <= src_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.verdict        = verdict_r;
  assign out_ch.source_address = src_r;

endmodule

@@ hw/rtl/icmp_reply_classifier_unit.sv @@
// On the last byte the summary is queued, then the verdict is registered.
// Throughput: one byte per cycle; the parser takes a byte every cycle while
// the two-entry summary queue has room, and the output register drains one
// verdict per cycle while ready, so even one-byte packets run back to back.
// Reset: synchronous, active low; clears parser state, queue, match
// registers and the output valid.
// ----------------------------------------------------------------------------
// ICMP reply classifier unit
// Parser front end, summary queue and classifier back end.
// ----------------------------------------------------------------------------
module icmp_reply_classifier_unit #(
  parameter int unsigned MAX_PACKET_BYTES = icru_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  icru_in_if.sink                         in_ch,
  icru_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [icru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [icru_pkg::CFG_DATA_W-1:0] cfg_data
);
  import icru_pkg::*;

  pkt_summary_t push_data, pop_data;
  logic         q_push, q_pop, q_full, q_empty;

  icru_parser #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (push_data)
  );

  icru_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  icru_classifier u_classifier (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .out_ch    (out_ch)
  );

endmodule

@@ hw/rtl/icru_checker.sv @@
// ----------------------------------------------------------------------------
// ICMP reply classifier checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module icru_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_verdict,
  input logic [31:0] out_source_address
);

  // a stalled result beat stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // a stalled result beat keeps its payload
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_verdict) && $stable(out_source_address))
    else $error("result payload changed while stalled");

  // reset drops any pending result
  a_reset_no_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // reset empties the queue, so input is taken at once
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready straight after reset");

endmodule

bind icmp_reply_classifier_unit icru_checker u_icru_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_verdict        (out_ch.verdict),
  .out_source_address (out_ch.source_address)
);

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// ICMP reply classifier testbench
// Sends whole IPv4 packets byte by byte into the classifier and checks each
// verdict and source address against a cycle-free model of the parser. A
// short directed set covers the length limits, odd header lengths, the
// echo-reply and time-exceeded paths and the oversized case. Random traffic
// follows under three idling regimes and several matcher settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import icru_pkg::*;

  localparam int unsigned MAX_BYTES = MAX_PACKET_BYTES_DEF;

  typedef struct {
    verdict_t    verdict;
    logic [31:0] source;
  } verdict_rec_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  icru_in_if  in_ch ();
  icru_out_if out_ch ();

  icmp_reply_classifier_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Matcher registers as last written
  logic [15:0] want_ident;
  logic [15:0] want_seq;
  logic [31:0] want_target;

  // Parser state of the packet in flight
  int unsigned kept_count;
  int unsigned hdr_len;
  int unsigned inner_hdr_len;
  logic [7:0]  icmp_type;
  logic [31:0] src_addr;
  logic [31:0] echo_id_seq;
  logic [31:0] quoted_id_seq;

  verdict_rec_t pending_verdicts[$];
  logic [7:0]   frame[$];

  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  bit          burst;
  int unsigned beats_sent;
  int unsigned verdicts_predicted;
  int unsigned fail_count;

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function automatic verdict_t classify_packet();
    logic [31:0] want;
    want = {want_ident, want_seq};
    if (kept_count < IP_MIN_HDR) return VERDICT_TOO_SHORT;
    if (kept_count < hdr_len + ICMP_HDR) return VERDICT_TOO_SHORT;
    if (icmp_type == TYPE_TIME_EXCEEDED) begin
      if (kept_count < hdr_len + ICMP_HDR + IP_MIN_HDR) return VERDICT_TOO_SHORT;
      if (kept_count < hdr_len + ICMP_HDR + inner_hdr_len + ICMP_HDR)
        return VERDICT_TOO_SHORT;
      return (quoted_id_seq == want) ? VERDICT_HOP : VERDICT_IGNORED;
    end
    if (icmp_type == TYPE_ECHO_REPLY) begin
      if (echo_id_seq == want && src_addr == want_target) return VERDICT_DEST;
      return VERDICT_IGNORED;
    end
    return VERDICT_IGNORED;
  endfunction

  task automatic parse_beat(input logic [7:0] value, input logic last);
    int unsigned idx;
    int unsigned inner_start;
    verdict_rec_t rec;
    // drop bytes past the size limit, the count saturates
    if (kept_count < MAX_BYTES) begin
      idx = kept_count;
      if (idx == 0) hdr_len = value[3:0] * 4;
      if (idx >= 12 && idx < 16) src_addr = {src_addr[23:0], value};
      if (idx == hdr_len) icmp_type = value;
      if (idx >= hdr_len + 4 && idx < hdr_len + 8)
        echo_id_seq = {echo_id_seq[23:0], value};
      if (idx == hdr_len + ICMP_HDR) inner_hdr_len = value[3:0] * 4;
      inner_start = hdr_len + ICMP_HDR + inner_hdr_len;
      if (idx >= inner_start + 4 && idx < inner_start + 8)
        quoted_id_seq = {quoted_id_seq[23:0], value};
      kept_count++;
    end
    if (last) begin
      rec.verdict = classify_packet();
      rec.source  = src_addr;
      pending_verdicts.push_back(rec);
      verdicts_predicted++;
      kept_count    = 0;
      hdr_len       = 0;
      inner_hdr_len = 0;
      icmp_type     = '0;
      src_addr      = '0;
      echo_id_seq   = '0;
      quoted_id_seq = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_verdict
    verdict_rec_t exp_rec;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict: none expected, got %0d (source %08h)",
               out_ch.verdict, out_ch.source_address);
        fail_count++;
      end else begin
        exp_rec = pending_verdicts.pop_front();
        if (out_ch.verdict !== exp_rec.verdict) begin
          $error("verdict: expected %0d, got %0d", exp_rec.verdict, out_ch.verdict);
          fail_count++;
        end
        if (out_ch.source_address !== exp_rec.source) begin
          $error("source_address: expected %08h, got %08h",
                 exp_rec.source, out_ch.source_address);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= burst || ($urandom_range(99) >= rcv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Called at a falling edge, returns at a falling edge
  task automatic send_beat(input logic [7:0] value, input logic last);
    while (!burst && $urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.pkt_byte  <= value;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
    parse_beat(value, last);
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_beat(frame[i], i == frame.size() - 1);
  endtask

  task automatic drain_verdicts();
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all three matcher registers, one per cycle; only while idle
  task automatic program_matchers(input logic [15:0] ident, input logic [15:0] seq,
                                  input logic [31:0] target);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_EXPECTED_IDENT;
    cfg_data  <= {16'h0, ident};
    @(negedge clk);
    cfg_index <= CFG_EXPECTED_SEQUENCE;
    cfg_data  <= {16'h0, seq};
    @(negedge clk);
    cfg_index <= CFG_TARGET_ADDRESS;
    cfg_data  <= target;
    @(negedge clk);
    cfg_we <= 1'b0;
    want_ident  = ident;
    want_seq    = seq;
    want_target = target;
  endtask

  // --------------------------------------------------------------------------
  // Packet builders
  // --------------------------------------------------------------------------
  task automatic frame_fill(input int unsigned len);
    frame.delete();
    repeat (len) frame.push_back(8'($urandom_range(255)));
  endtask

  // Big-endian store, clipped at the end of the frame
  task automatic frame_put(input int unsigned at, input logic [31:0] value,
                           input int unsigned nbytes);
    for (int unsigned k = 0; k < nbytes; k++)
      if (at + k < frame.size()) frame[at + k] = 8'(value >> (8 * (nbytes - 1 - k)));
  endtask

  task automatic frame_cut(input int unsigned len);
    while (frame.size() > len) void'(frame.pop_back());
  endtask

  task automatic build_echo(input int unsigned ihl, input logic [15:0] ident,
                            input logic [15:0] seq, input logic [31:0] src,
                            input int unsigned payload);
    int unsigned oh;
    oh = ihl * 4;
    frame_fill(((oh + 8 > 20) ? oh + 8 : 20) + payload);
    frame_put(0, 32'({4'h4, ihl[3:0]}), 1);
    frame_put(12, src, 4);
    frame_put(oh, 32'(TYPE_ECHO_REPLY), 1);
    frame_put(oh + 4, {ident, seq}, 4);
  endtask

  task automatic build_time_exceeded(input int unsigned ihl, input int unsigned inner_ihl,
                                     input logic [15:0] ident, input logic [15:0] seq,
                                     input logic [31:0] src, input int unsigned extra);
    int unsigned oh;
    int unsigned ih;
    int unsigned quoted;
    oh     = ihl * 4;
    ih     = inner_ihl * 4;
    quoted = oh + 8 + ((ih + 8 > 20) ? ih + 8 : 20);
    frame_fill(((quoted > 20) ? quoted : 20) + extra);
    frame_put(0, 32'({4'h4, ihl[3:0]}), 1);
    frame_put(12, src, 4);
    frame_put(oh, 32'(TYPE_TIME_EXCEEDED), 1);
    frame_put(oh + 8, 32'({4'h4, inner_ihl[3:0]}), 1);
    frame_put(oh + 8 + ih, 32'd8, 1);
    frame_put(oh + 8 + ih + 4, {ident, seq}, 4);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_matchers();
    build_echo(5, 16'h0, 16'h0, 32'h0, 0);
    send_frame();
    build_time_exceeded(5, 5, 16'h0, 16'h0, 32'hC0A8_0001, 0);
    send_frame();
    drain_verdicts();
  endtask

  task automatic test_short_packets();
    frame_fill(1);
    frame[0] = 8'hFF;
    send_frame();
    build_echo(5, want_ident, want_seq, want_target, 0);
    frame_cut(19);
    send_frame();
    build_echo(5, want_ident, want_seq, want_target, 0);
    frame_cut(20);
    send_frame();
    build_echo(5, want_ident, want_seq, want_target, 0);
    frame_cut(27);
    send_frame();
    drain_verdicts();
  endtask

  task automatic test_echo_reply();
    program_matchers(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    build_echo(5, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 4);
    send_frame();
    build_echo(5, 16'hFFFE, 16'hFFFF, 32'hFFFF_FFFF, 0);
    send_frame();
    build_echo(5, 16'hFFFF, 16'h7FFF, 32'hFFFF_FFFF, 0);
    send_frame();
    build_echo(5, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFE, 0);
    send_frame();
    drain_verdicts();
  endtask

  task automatic test_time_exceeded();
    program_matchers(16'h4E39, 16'h0001, 32'h0A00_0001);
    build_time_exceeded(5, 5, 16'h4E39, 16'h0001, 32'h5555_AAAA, 0);
    send_frame();
    build_time_exceeded(5, 5, 16'h4E39, 16'h0002, 32'h5555_AAAA, 0);
    send_frame();
    // one byte short of the quoted IP header
    build_time_exceeded(5, 5, 16'h4E39, 16'h0001, 32'h1234_5678, 0);
    frame_cut(47);
    send_frame();
    // long quoted header, cut inside the quoted IP header
    build_time_exceeded(5, 15, 16'h4E39, 16'h0001, 32'h1234_5678, 0);
    frame_cut(80);
    send_frame();
    build_time_exceeded(5, 15, 16'h4E39, 16'h0001, 32'h1234_5678, 0);
    send_frame();
    drain_verdicts();
  endtask

  task automatic test_odd_header_len();
    build_echo(0, want_ident, want_seq, want_target, 0);
    send_frame();
    build_echo(2, want_ident, want_seq, want_target, 0);
    send_frame();
    build_echo(15, want_ident, want_seq, want_target, 0);
    send_frame();
    build_echo(15, want_ident, want_seq, want_target, 0);
    frame_cut(67);
    send_frame();
    build_time_exceeded(0, 1, want_ident, want_seq, want_target, 0);
    send_frame();
    drain_verdicts();
  endtask

  task automatic test_other_types();
    build_echo(5, want_ident, want_seq, want_target, 0);
    frame_put(20, 32'd3, 1);
    send_frame();
    build_echo(5, want_ident, want_seq, want_target, 0);
    frame_put(20, 32'd8, 1);
    send_frame();
    drain_verdicts();
  endtask

  task automatic test_oversized();
    build_echo(5, want_ident, want_seq, want_target, MAX_BYTES + 4 - 28);
    send_frame();
    build_time_exceeded(5, 5, want_ident, want_seq, 32'h8000_0001, MAX_BYTES - 56);
    send_frame();
    drain_verdicts();
  endtask

  task automatic send_random_packet();
    int unsigned kind;
    int unsigned ihl;
    int unsigned inner_ihl;
    logic [15:0] ident;
    logic [15:0] seq;
    logic [31:0] src;
    ident     = ($urandom_range(99) < 75) ? want_ident : 16'($urandom_range(16'hFFFF));
    seq       = ($urandom_range(99) < 75) ? want_seq : 16'($urandom_range(16'hFFFF));
    src       = ($urandom_range(99) < 75) ? want_target : 32'($urandom());
    ihl       = ($urandom_range(99) < 80) ? 5 : $urandom_range(15);
    inner_ihl = ($urandom_range(99) < 80) ? 5 : $urandom_range(15);
    kind      = $urandom_range(99);
    if (kind < 40) begin
      build_echo(ihl, ident, seq, src, $urandom_range(16));
    end else if (kind < 75) begin
      build_time_exceeded(ihl, inner_ihl, ident, seq, src, $urandom_range(8));
    end else if (kind < 85) begin
      build_echo(ihl, ident, seq, src, $urandom_range(8));
      frame_put(ihl * 4, $urandom_range(255), 1);
    end else begin
      frame_fill($urandom_range(1, 64));
    end
    if ($urandom_range(99) < 15) frame_cut($urandom_range(1, frame.size()));
    burst = ($urandom_range(9) == 0);
    send_frame();
    // hold off now and then until the block has answered everything
    if ($urandom_range(99) < 3) drain_verdicts();
  endtask

  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input logic [15:0] ident, input logic [15:0] seq,
                                     input logic [31:0] target);
    int unsigned beats_start;
    int unsigned verdicts_start;
    drain_verdicts();
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    program_matchers(ident, seq, target);
    beats_start    = beats_sent;
    verdicts_start = verdicts_predicted;
    while (beats_sent - beats_start < 240 || verdicts_predicted - verdicts_start < 15)
      send_random_packet();
    burst = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned wait_cycles;
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_EXPECTED_IDENT;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.pkt_byte  = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    want_ident      = '0;
    want_seq        = '0;
    want_target     = '0;
    kept_count      = 0;
    hdr_len         = 0;
    inner_hdr_len   = 0;
    icmp_type       = '0;
    src_addr        = '0;
    echo_id_seq     = '0;
    quoted_id_seq   = '0;
    snd_idle_pct    = 29;
    rcv_idle_pct    = 52;
    burst           = 1'b0;
    beats_sent      = 0;
    verdicts_predicted = 0;
    fail_count      = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_matchers();
    test_short_packets();
    test_echo_reply();
    test_time_exceeded();
    test_odd_header_len();
    test_other_types();
    test_oversized();
    test_random_traffic(29, 52, 16'($urandom_range(16'hFFFF)),
                        16'($urandom_range(16'hFFFF)), 32'($urandom()));
    test_random_traffic(52, 29, 16'h0000, 16'hFFFF, 32'($urandom()));
    test_random_traffic(0, 0, 16'($urandom_range(16'hFFFF)), 16'h0000, 32'h0000_0000);

    in_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (pending_verdicts.size() != 0 && wait_cycles < 2000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (8) @(negedge clk);
    if (pending_verdicts.size() != 0) begin
      $error("verdict: %0d expected but never received", pending_verdicts.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
